>>> rtl/rpsd_pkg.sv
// shared types and constants of the run-length pixel stream decoder
`timescale 1ns / 1ps
`default_nettype none

package rpsd_pkg;

  localparam int unsigned WORD_W       = 16;
  localparam int unsigned FRAME_CFG_W  = 21;
  localparam int unsigned CFG_DATA_W   = 21;
  localparam int unsigned CFG_INDEX_W  = 2;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QUEUE_PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FRAME_PIXELS  = 2'd0,
    CFG_TRANS_ENABLE  = 2'd1,
    CFG_TRANS_COLOR   = 2'd2,
    CFG_FILL_COLOR    = 2'd3
  } cfg_index_e;

  typedef enum logic [2:0] {
    MODE_HEADER  = 3'b001,
    MODE_LITERAL = 3'b010,
    MODE_REPEAT  = 3'b100
  } mode_e;

  // one pixel job handed from the front to the back
  typedef struct packed {
    logic              start;    // frame start seen since the previous job
    logic              is_rep;   // repeat run, else a literal pixel
    logic [WORD_W-1:0] run_len;  // requested repeat length
    logic [WORD_W-1:0] word;     // raw pixel colour
  } entry_t;

  typedef struct packed {
    logic [FRAME_CFG_W-1:0] frame_pixels;
    logic                   trans_en;
    logic [WORD_W-1:0]      trans_color;
    logic [WORD_W-1:0]      fill_color;
  } cfg_t;

endpackage

`default_nettype wire

>>> rtl/rpsd_front.sv
// front part: tracks run headers and turns pixel words into jobs
`timescale 1ns / 1ps
`default_nettype none

module rpsd_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      accept_i,
  input  wire logic [rpsd_pkg::WORD_W-1:0] word_i,
  input  wire logic                      start_i,
  output rpsd_pkg::entry_t               entry_o,
  output logic                           push_o
);

  rpsd_pkg::mode_e               mode_q, mode_d;
  logic [rpsd_pkg::WORD_W-1:0]   run_q, run_d;
  logic                          pend_q, pend_d;
  rpsd_pkg::mode_e               mode_cur;

  always_comb begin
    mode_cur = start_i ? rpsd_pkg::MODE_HEADER : mode_q;
    mode_d   = mode_q;
    run_d    = run_q;
    push_o   = 1'b0;
    entry_o.start   = pend_q;
    entry_o.is_rep  = 1'b0;
    entry_o.run_len = run_q;
    entry_o.word    = word_i;
    if (accept_i) begin
      unique case (mode_cur)
        rpsd_pkg::MODE_LITERAL: begin
          push_o = 1'b1;
          run_d  = run_q - 16'd1;
          if (run_q == 16'd1) begin
            mode_d = rpsd_pkg::MODE_HEADER;
          end else begin
            mode_d = rpsd_pkg::MODE_LITERAL;
          end
        end
        rpsd_pkg::MODE_REPEAT: begin
          push_o         = 1'b1;
          entry_o.is_rep = 1'b1;
          run_d          = '0;
          mode_d         = rpsd_pkg::MODE_HEADER;
        end
        default: begin
          mode_d = rpsd_pkg::MODE_HEADER;
          if (word_i == '0) begin
            run_d = '0;
          end else if (word_i[rpsd_pkg::WORD_W-1]) begin
            // negative header, the most negative one gives 0x8000
            run_d  = 16'd0 - word_i;
            mode_d = rpsd_pkg::MODE_LITERAL;
          end else begin
            run_d  = word_i;
            mode_d = rpsd_pkg::MODE_REPEAT;
          end
        end
      endcase
    end
    // a frame start is handed on with the next job
    if (accept_i) begin
      pend_d = push_o ? 1'b0 : (pend_q | start_i);
    end else begin
      pend_d = pend_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= rpsd_pkg::MODE_HEADER;
      run_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      run_q  <= run_d;
      pend_q <= pend_d;
    end
  end

  a_literal_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == rpsd_pkg::MODE_LITERAL |-> run_q != '0)
    else $error("literal mode with an empty run");

  a_header_start_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && start_i |-> !push_o)
    else $error("frame start word produced a pixel job");

endmodule

`default_nettype wire

>>> rtl/rpsd_queue.sv
// short job queue between the front and back parts
`timescale 1ns / 1ps
`default_nettype none

module rpsd_queue (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire rpsd_pkg::entry_t entry_i,
  output logic            full_o,
  output logic            valid_o,
  input  wire logic       pop_i,
  output rpsd_pkg::entry_t entry_o
);

  rpsd_pkg::entry_t                     mem_q [rpsd_pkg::QUEUE_DEPTH];
  logic [rpsd_pkg::QUEUE_PTR_W-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [rpsd_pkg::QUEUE_CNT_W-1:0]     cnt_q, cnt_d;
  logic                                 do_push, do_pop;

  localparam logic [rpsd_pkg::QUEUE_PTR_W-1:0] LastPtr =
    rpsd_pkg::QUEUE_PTR_W'(rpsd_pkg::QUEUE_DEPTH - 1);

  assign full_o  = (cnt_q == rpsd_pkg::QUEUE_CNT_W'(rpsd_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= rpsd_pkg::QUEUE_CNT_W'(rpsd_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_lost_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job pushed into a full queue");

endmodule

`default_nettype wire

>>> rtl/rpsd_back.sv
// back part: pixel counting, run truncation, colour substitution, output register
`timescale 1ns / 1ps
`default_nettype none

module rpsd_back #(
  parameter int unsigned PIXEL_COUNT_BITS = 21
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire rpsd_pkg::cfg_t              cfg_i,
  input  wire logic                        job_valid_i,
  input  wire rpsd_pkg::entry_t            job_i,
  output logic                             job_pop_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [rpsd_pkg::WORD_W-1:0]      out_color_o,
  output logic [rpsd_pkg::WORD_W-1:0]      out_count_o,
  output logic                             out_last_o
);

  localparam int unsigned P  = PIXEL_COUNT_BITS;
  localparam int unsigned CW = (P > rpsd_pkg::WORD_W) ? P : rpsd_pkg::WORD_W;

  logic [P-1:0]                  dec_q, dec_d;
  logic                          done_q, done_d;
  logic                          out_valid_q, out_valid_d;
  logic [rpsd_pkg::WORD_W-1:0]   out_color_q, out_count_q;
  logic                          out_last_q;

  logic [P-1:0]                  total, dec_base, room, dec_new;
  logic                          done_base, take, last;
  logic [CW-1:0]                 run_cw, room_cw, n_cw;
  logic [rpsd_pkg::WORD_W-1:0]   color;

  assign take      = job_valid_i && (!out_valid_q || out_ready_i);
  assign job_pop_o = take;

  always_comb begin
    total     = P'(cfg_i.frame_pixels);
    dec_base  = job_i.start ? '0 : dec_q;
    done_base = job_i.start ? 1'b0 : done_q;
    // total already reached still lets one pixel through
    room      = (total > dec_base) ? (total - dec_base) : P'(1);
    run_cw    = CW'(job_i.run_len);
    room_cw   = CW'(room);
    if (job_i.is_rep) begin
      n_cw = (run_cw < room_cw) ? run_cw : room_cw;
    end else begin
      n_cw = CW'(1);
    end
    dec_new = dec_base + P'(n_cw);
    last    = (total <= dec_new);
    if (cfg_i.trans_en && job_i.word == cfg_i.trans_color) begin
      color = cfg_i.fill_color;
    end else begin
      color = job_i.word;
    end
  end

  always_comb begin
    dec_d       = dec_q;
    done_d      = done_q;
    out_valid_d = out_valid_q;
    if (take) begin
      if (done_base) begin
        dec_d       = dec_base;
        done_d      = done_base;
        out_valid_d = 1'b0;
      end else begin
        dec_d       = dec_new;
        done_d      = last;
        out_valid_d = 1'b1;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_q       <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      dec_q       <= dec_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && !done_base) begin
      out_color_q <= color;
      out_count_q <= n_cw[rpsd_pkg::WORD_W-1:0];
      out_last_q  <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_color_o = out_color_q;
  assign out_count_o = out_count_q;
  assign out_last_o  = out_last_q;

  a_dropped_job_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && done_base |=> !out_valid_q)
    else $error("job after frame end produced a result");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_count_q != '0)
    else $error("result with a zero repeat count");

  a_last_marks_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_last_q |-> done_q)
    else $error("frame last sent while frame not done");

endmodule

`default_nettype wire

>>> rtl/rle_pixel_stream_decoder.sv
// top level of the run-length RGB565 pixel stream decoder
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata data_word, tuser frame_start
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata pixel_color, repeat_count; tlast
//  cfg       in   cfg_we_i                      cfg_index_i, cfg_wdata_i
//
// one coded word is taken per cycle while the job queue is not full; a pixel word
// reaches m_axis through the queue write, then the output register; header words
// give no result; the front tracks run headers, a two-entry job queue feeds the back,
// which counts pixels and truncates runs against the frame total
// s_axis_tready drops only when the job queue is full; the back stalls on m_axis_tready
// reset clears mode, counters, queue and registers; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module rle_pixel_stream_decoder #(
  parameter int unsigned PIXEL_COUNT_BITS = 21
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration
  input  wire logic                               cfg_we_i,
  input  wire logic [rpsd_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  wire logic [rpsd_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // coded word stream
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [15:0]                        s_axis_tdata,  // [15:0] data_word
  input  wire logic                               s_axis_tuser,  // [0] frame_start
  // decoded run stream
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [31:0]                             m_axis_tdata,  // [15:0] pixel_color,
                                                                 // [31:16] repeat_count
  output logic                                    m_axis_tlast
);

  rpsd_pkg::cfg_t    cfg_q;
  rpsd_pkg::entry_t  push_entry, head_entry;
  logic              push, q_full, q_valid, q_pop, accept;
  logic [15:0]       out_color, out_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (rpsd_pkg::cfg_index_e'(cfg_index_i))
        rpsd_pkg::CFG_FRAME_PIXELS: cfg_q.frame_pixels <= cfg_wdata_i;
        rpsd_pkg::CFG_TRANS_ENABLE: cfg_q.trans_en     <= cfg_wdata_i[0];
        rpsd_pkg::CFG_TRANS_COLOR:  cfg_q.trans_color  <= cfg_wdata_i[15:0];
        rpsd_pkg::CFG_FILL_COLOR:   cfg_q.fill_color   <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  rpsd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .word_i   (s_axis_tdata),
    .start_i  (s_axis_tuser),
    .entry_o  (push_entry),
    .push_o   (push)
  );

  rpsd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .entry_o (head_entry)
  );

  rpsd_back #(
    .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (q_valid),
    .job_i       (head_entry),
    .job_pop_o   (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_color_o (out_color),
    .out_count_o (out_count),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {out_count, out_color};

endmodule

`default_nettype wire
